[rtl/core/mkdb_pkg.sv]
// Shared constants, register indexes and lane event type for the key debouncer.
package mkdb_pkg;

    // Default sizing
    localparam int unsigned NUM_KEYS_DEF = 8;
    localparam int unsigned AGE_BITS_DEF = 16;

    // Fixed field widths
    localparam int unsigned MASK_W     = 8;
    localparam int unsigned DEB_W      = 10;
    localparam int unsigned LONG_W     = 16;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE   = 2'd0,
        CFG_LONG_PRESS = 2'd1,
        CFG_ACTIVE_LOW = 2'd2
    } t_cfg_idx;

    // Register reset values
    localparam logic [DEB_W-1:0]  DEBOUNCE_RST   = 10'd20;
    localparam logic [LONG_W-1:0] LONG_PRESS_RST = 16'd1000;
    localparam logic              ACTIVE_LOW_RST = 1'b1;

    // What one key lane reports for one tick
    typedef struct packed {
        logic short_evt;
        logic long_evt;
        logic pressed;
    } t_lane_evt;

endpackage

[rtl/core/multi_key_debounce_long_press.sv]
// Top level: config registers, per-key debounce lanes and result merge with output buffering.
// Debouncer with short and long press detection for NUM_KEYS keys, of which the first
// eight are visible on the 8-bit pin and mask fields. Each input beat is one tick of
// raw pin levels; every key lane updates in the cycle its beat is accepted, so the
// block takes one beat per clock while o_stall is low; results are registered. A two-entry
// output buffer (output register plus skid) keeps input taking beats while a result
// waits; o_stall rises only when both entries are held. The first beat after reset
// loads key state and reports no events. Configuration writes are taken at any time but
// should be issued only while no beat is in flight.
module multi_key_debounce_long_press #(
    parameter int unsigned NUM_KEYS = mkdb_pkg::NUM_KEYS_DEF,
    parameter int unsigned AGE_BITS = mkdb_pkg::AGE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write port
    input  logic                                i_cfg_we,
    input  logic [mkdb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mkdb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // tick input
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [mkdb_pkg::MASK_W-1:0]         i_pin_levels,
    // result output
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [mkdb_pkg::MASK_W-1:0]         o_short_mask,
    output logic [mkdb_pkg::MASK_W-1:0]         o_long_mask,
    output logic [mkdb_pkg::MASK_W-1:0]         o_pressed_mask
);

    logic [mkdb_pkg::DEB_W-1:0]  r_debounce_ticks;
    logic [mkdb_pkg::LONG_W-1:0] r_long_press_ticks;
    logic                        r_active_low;
    logic                        r_started;

    logic                        accept;
    logic                        full;
    logic [NUM_KEYS-1:0]         key_pressed;
    mkdb_pkg::t_lane_evt         evt [NUM_KEYS];

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks   <= mkdb_pkg::DEBOUNCE_RST;
            r_long_press_ticks <= mkdb_pkg::LONG_PRESS_RST;
            r_active_low       <= mkdb_pkg::ACTIVE_LOW_RST;
        end else if (i_cfg_we) begin
            unique case (mkdb_pkg::t_cfg_idx'(i_cfg_index))
                mkdb_pkg::CFG_DEBOUNCE: begin
                    r_debounce_ticks <= i_cfg_data[mkdb_pkg::DEB_W-1:0];
                end
                mkdb_pkg::CFG_LONG_PRESS: begin
                    r_long_press_ticks <= i_cfg_data[mkdb_pkg::LONG_W-1:0];
                end
                mkdb_pkg::CFG_ACTIVE_LOW: begin
                    r_active_low <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign accept  = i_valid && !full;
    assign o_stall = full;

    // First accepted tick only loads lane state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
        end else if (accept) begin
            r_started <= 1'b1;
        end
    end

    // Key lanes
    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        if (k < mkdb_pkg::MASK_W) begin : g_pin
            assign key_pressed[k] = i_pin_levels[k] ^ r_active_low;
        end else begin : g_nopin
            assign key_pressed[k] = r_active_low;
        end

        mkdb_lane #(
            .AGE_BITS (AGE_BITS)
        ) u_lane (
            .i_clk              (i_clk),
            .i_rst_n            (i_rst_n),
            .i_en               (accept),
            .i_load             (!r_started),
            .i_pressed          (key_pressed[k]),
            .i_debounce_ticks   (r_debounce_ticks),
            .i_long_press_ticks (r_long_press_ticks),
            .o_evt              (evt[k])
        );
    end

    // Mask merge and output buffering
    mkdb_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (accept),
        .i_evt          (evt),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_short_mask   (o_short_mask),
        .o_long_mask    (o_long_mask),
        .o_pressed_mask (o_pressed_mask),
        .o_full         (full)
    );

    // A key never reports short and long on the same tick
    a_short_long_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_short_mask & o_long_mask) == '0))
        else $error("short and long event on the same key");

    // Long event only while held, short event only after release
    a_evt_vs_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (((o_long_mask & ~o_pressed_mask) == '0) &&
                     ((o_short_mask & o_pressed_mask) == '0)))
        else $error("event disagrees with debounced state");

    // The loading tick gives no events
    a_first_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !r_started) |=> (o_short_mask == '0) && (o_long_mask == '0))
        else $error("events reported on the loading tick");

endmodule

[rtl/core/mkdb_lane.sv]
// One key lane: raw level tracking, debounce counter, press age and event detection.
module mkdb_lane #(
    parameter int unsigned AGE_BITS = mkdb_pkg::AGE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_load,
    input  logic                            i_pressed,
    input  logic [mkdb_pkg::DEB_W-1:0]      i_debounce_ticks,
    input  logic [mkdb_pkg::LONG_W-1:0]     i_long_press_ticks,
    output mkdb_pkg::t_lane_evt             o_evt
);

    localparam int unsigned CMP_W = (AGE_BITS > mkdb_pkg::LONG_W) ? AGE_BITS
                                                                  : mkdb_pkg::LONG_W;
    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    logic                r_last_raw, n_last_raw;
    logic                r_debounced, n_debounced;
    logic                r_long_sent, n_long_sent;
    logic [AGE_BITS-1:0] r_stable_age, n_stable_age;
    logic [AGE_BITS-1:0] r_press_age, n_press_age;

    logic [AGE_BITS-1:0] stable_inc;
    logic [AGE_BITS-1:0] press_inc;
    logic                deb_done;
    logic                long_done;
    logic                short_evt;
    logic                long_evt;

    // Saturating age increments
    assign stable_inc = (r_stable_age == AGE_MAX) ? r_stable_age : r_stable_age + 1'b1;
    assign press_inc  = (r_press_age == AGE_MAX) ? r_press_age : r_press_age + 1'b1;

    // Next state for one tick
    always_comb begin
        n_last_raw   = r_last_raw;
        n_debounced  = r_debounced;
        n_long_sent  = r_long_sent;
        n_stable_age = stable_inc;
        n_press_age  = press_inc;
        short_evt    = 1'b0;
        long_evt     = 1'b0;
        deb_done     = 1'b0;
        long_done    = 1'b0;
        if (i_load) begin
            n_last_raw   = i_pressed;
            n_debounced  = i_pressed;
            n_long_sent  = 1'b0;
            n_stable_age = '0;
            n_press_age  = '0;
        end else begin
            // raw change restarts the stability count
            if (i_pressed != r_last_raw) begin
                n_last_raw   = i_pressed;
                n_stable_age = '0;
            end
            deb_done = (CMP_W'(n_stable_age) >= CMP_W'(i_debounce_ticks));
            if (deb_done && (i_pressed != r_debounced)) begin
                n_debounced = i_pressed;
                if (i_pressed) begin
                    n_press_age = '0;
                    n_long_sent = 1'b0;
                end else if (!r_long_sent) begin
                    short_evt = 1'b1;
                end
            end
            // one long event per press
            long_done = (CMP_W'(n_press_age) >= CMP_W'(i_long_press_ticks));
            if (n_debounced && !n_long_sent && long_done) begin
                n_long_sent = 1'b1;
                long_evt    = 1'b1;
            end
        end
    end

    // State update on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw  <= 1'b0;
            r_debounced <= 1'b0;
            r_long_sent <= 1'b0;
        end else if (i_en) begin
            r_last_raw  <= n_last_raw;
            r_debounced <= n_debounced;
            r_long_sent <= n_long_sent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stable_age <= n_stable_age;
            r_press_age  <= n_press_age;
        end
    end

    assign o_evt.short_evt = short_evt;
    assign o_evt.long_evt  = long_evt;
    assign o_evt.pressed   = n_debounced;

endmodule

[rtl/core/mkdb_merge.sv]
// Merges lane events into the result masks and holds them in an output register with skid.
module mkdb_merge #(
    parameter int unsigned NUM_KEYS = mkdb_pkg::NUM_KEYS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  mkdb_pkg::t_lane_evt               i_evt [NUM_KEYS],
    input  logic                              i_stall,
    output logic                              o_valid,
    output logic [mkdb_pkg::MASK_W-1:0]       o_short_mask,
    output logic [mkdb_pkg::MASK_W-1:0]       o_long_mask,
    output logic [mkdb_pkg::MASK_W-1:0]       o_pressed_mask,
    output logic                              o_full
);

    localparam int unsigned MW = mkdb_pkg::MASK_W;

    logic [MW-1:0] short_m, long_m, pressed_m;

    logic          r_out_valid;
    logic [MW-1:0] r_out_short, r_out_long, r_out_pressed;
    logic          r_skd_valid;
    logic [MW-1:0] r_skd_short, r_skd_long, r_skd_pressed;
    logic          take;
    logic          out_free;

    // Gather lane bits; mask positions without a key stay clear
    for (genvar k = 0; k < MW; k++) begin : g_mask
        if (k < NUM_KEYS) begin : g_key
            assign short_m[k]   = i_evt[k].short_evt;
            assign long_m[k]    = i_evt[k].long_evt;
            assign pressed_m[k] = i_evt[k].pressed;
        end else begin : g_none
            assign short_m[k]   = 1'b0;
            assign long_m[k]    = 1'b0;
            assign pressed_m[k] = 1'b0;
        end
    end

    assign take     = r_out_valid && !i_stall;
    assign out_free = !r_out_valid || take;

    // Output register and skid control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else begin
            priority if (r_skd_valid) begin
                if (take) begin
                    r_skd_valid <= 1'b0;
                end
            end else if (i_load) begin
                if (out_free) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skd_valid <= 1'b1;
                end
            end else if (take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload moves
    always_ff @(posedge i_clk) begin
        if (r_skd_valid && take) begin
            r_out_short   <= r_skd_short;
            r_out_long    <= r_skd_long;
            r_out_pressed <= r_skd_pressed;
        end else if (i_load && out_free) begin
            r_out_short   <= short_m;
            r_out_long    <= long_m;
            r_out_pressed <= pressed_m;
        end
        if (i_load && !out_free) begin
            r_skd_short   <= short_m;
            r_skd_long    <= long_m;
            r_skd_pressed <= pressed_m;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_short_mask   = r_out_short;
    assign o_long_mask    = r_out_long;
    assign o_pressed_mask = r_out_pressed;
    assign o_full         = r_skd_valid;

    // Skid only fills behind a held output beat
    a_skd_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |-> r_out_valid)
        else $error("skid holds a beat while output register is empty");

    // A beat loaded behind a stalled output lands in the skid
    a_skd_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && r_out_valid && i_stall) |=> r_skd_valid)
        else $error("beat lost behind stalled output");

    // No new beat while the skid is occupied
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |-> !i_load)
        else $error("beat loaded while skid full");

endmodule

[tb/multi_key_debounce_long_press_tb.sv]
// Self-checking testbench for the eight-key debouncer with short and long press events.
`timescale 1ns / 1ps

module multi_key_debounce_long_press_tb;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int NUM_PHASES     = 12;
    localparam int DIR_N          = 25;
    localparam logic [15:0] AGE_MAX = 16'hFFFF;
    // index 3 is not a register; writes to it must change nothing
    localparam logic [mkdb_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    // one result beat
    typedef struct packed {
        logic [7:0] short_mask;
        logic [7:0] long_mask;
        logic [7:0] pressed_mask;
    } t_tick_result;

    // per input beat: optional hand-typed expectation
    typedef struct packed {
        bit           typed;
        t_tick_result res;
    } t_tick_note;

    // directed row: configuration, pins, optional typed result
    typedef struct packed {
        logic [9:0]  deb;
        logic [15:0] lng;
        logic        al;
        logic [7:0]  pins;
        bit          typed;
        logic [7:0]  exp_short;
        logic [7:0]  exp_long;
        logic [7:0]  exp_pressed;
    } t_dir_row;

    typedef enum {HOLD_BRIEF, HOLD_SETTLE, HOLD_LONG} t_hold_kind;

    localparam t_dir_row DIR_ROWS [DIR_N] = '{
        // first tick after reset only loads state
        '{10'd20, 16'd1000, 1'b1, 8'hF0, 1'b1, 8'h00, 8'h00, 8'h0F},
        // zero long time: keys pressed at load still give a long event
        '{10'd0,  16'd0,    1'b1, 8'hF0, 1'b1, 8'h00, 8'h0F, 8'h0F},
        '{10'd0,  16'd0,    1'b1, 8'hFF, 1'b1, 8'h00, 8'h00, 8'h00},
        // zero debounce and zero long: press and long on one tick
        '{10'd0,  16'd0,    1'b1, 8'h00, 1'b1, 8'h00, 8'hFF, 8'hFF},
        '{10'd0,  16'd0,    1'b1, 8'hFF, 1'b1, 8'h00, 8'h00, 8'h00},
        '{10'd0,  16'd5,    1'b1, 8'h00, 1'b1, 8'h00, 8'h00, 8'hFF},
        '{10'd0,  16'd5,    1'b1, 8'hFF, 1'b1, 8'hFF, 8'h00, 8'h00},
        // active high, short debounce, long press on key 0
        '{10'd2,  16'd3,    1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
        '{10'd2,  16'd3,    1'b0, 8'h01, 1'b0, 8'h00, 8'h00, 8'h00},
        '{10'd2,  16'd3,    1'b0, 8'h01, 1'b0, 8'h00, 8'h00, 8'h00},
        '{10'd2,  16'd3,    1'b0, 8'h01, 1'b0, 8'h00, 8'h00, 8'h00},
        '{10'd2,  16'd3,    1'b0, 8'h01, 1'b0, 8'h00, 8'h00, 8'h00},
        '{10'd2,  16'd3,    1'b0, 8'h01, 1'b0, 8'h00, 8'h00, 8'h00},
        '{10'd2,  16'd3,    1'b0, 8'h01, 1'b0, 8'h00, 8'h00, 8'h00},
        '{10'd2,  16'd3,    1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
        '{10'd2,  16'd3,    1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
        '{10'd2,  16'd3,    1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
        // bounce on key 7, then a press, then alternating patterns
        '{10'd2,  16'd3,    1'b0, 8'h80, 1'b0, 8'h00, 8'h00, 8'h00},
        '{10'd2,  16'd3,    1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
        '{10'd2,  16'd3,    1'b0, 8'h80, 1'b0, 8'h00, 8'h00, 8'h00},
        '{10'd2,  16'd3,    1'b0, 8'h80, 1'b0, 8'h00, 8'h00, 8'h00},
        '{10'd2,  16'd3,    1'b0, 8'h80, 1'b0, 8'h00, 8'h00, 8'h00},
        '{10'd2,  16'd3,    1'b0, 8'h55, 1'b0, 8'h00, 8'h00, 8'h00},
        '{10'd2,  16'd3,    1'b0, 8'hAA, 1'b0, 8'h00, 8'h00, 8'h00},
        '{10'd2,  16'd3,    1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00}
    };

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [mkdb_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [mkdb_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                            i_valid;
    logic                            o_stall;
    logic [mkdb_pkg::MASK_W-1:0]     i_pin_levels;
    logic                            o_valid;
    logic                            i_stall;
    logic [mkdb_pkg::MASK_W-1:0]     o_short_mask;
    logic [mkdb_pkg::MASK_W-1:0]     o_long_mask;
    logic [mkdb_pkg::MASK_W-1:0]     o_pressed_mask;

    multi_key_debounce_long_press dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pin_levels   (i_pin_levels),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_short_mask   (o_short_mask),
        .o_long_mask    (o_long_mask),
        .o_pressed_mask (o_pressed_mask)
    );

    // predictor copy of configuration and key state
    logic [9:0]  mdl_debounce;
    logic [15:0] mdl_long;
    logic        mdl_active_low;
    logic        keys_started;
    logic        raw_q     [8];
    logic        deb_q     [8];
    logic        long_done [8];
    logic [15:0] stable_cnt[8];
    logic [15:0] hold_cnt  [8];

    t_tick_result pending_results[$];
    t_tick_note   tick_notes[$];

    int quiet_cycles = 0;
    int mismatches   = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int short_events = 0;
    int long_events  = 0;
    int gap_pct      = 0;
    int stall_pct    = 0;

    // stimulus-side view of what was last applied
    int         cur_deb = 20;
    int         cur_lng = 1000;
    bit         cur_al  = 1'b1;
    logic [7:0] cur_pins = 8'hFF;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void reset_keys();
        int k;
        mdl_debounce   = mkdb_pkg::DEBOUNCE_RST;
        mdl_long       = mkdb_pkg::LONG_PRESS_RST;
        mdl_active_low = mkdb_pkg::ACTIVE_LOW_RST;
        keys_started   = 1'b0;
        for (k = 0; k < 8; k++) begin
            raw_q[k]      = 1'b0;
            deb_q[k]      = 1'b0;
            long_done[k]  = 1'b0;
            stable_cnt[k] = '0;
            hold_cnt[k]   = '0;
        end
    endfunction

    // one tick of all eight keys
    function automatic t_tick_result debounce_tick(logic [7:0] pins);
        t_tick_result r;
        logic         lvl;
        int           k;
        r = '0;
        for (k = 0; k < 8; k++) begin
            lvl = mdl_active_low ? ~pins[k] : pins[k];
            if (!keys_started) begin
                raw_q[k]      = lvl;
                deb_q[k]      = lvl;
                long_done[k]  = 1'b0;
                stable_cnt[k] = '0;
                hold_cnt[k]   = '0;
            end else begin
                if (stable_cnt[k] != AGE_MAX) stable_cnt[k] = stable_cnt[k] + 16'd1;
                if (hold_cnt[k] != AGE_MAX) hold_cnt[k] = hold_cnt[k] + 16'd1;
                if (lvl != raw_q[k]) begin
                    raw_q[k]      = lvl;
                    stable_cnt[k] = '0;
                end
                // level accepted once stable long enough
                if (stable_cnt[k] >= {6'd0, mdl_debounce} && lvl != deb_q[k]) begin
                    deb_q[k] = lvl;
                    if (lvl) begin
                        hold_cnt[k]  = '0;
                        long_done[k] = 1'b0;
                    end else if (!long_done[k]) begin
                        r.short_mask[k] = 1'b1;
                    end
                end
                if (deb_q[k] && !long_done[k] && hold_cnt[k] >= mdl_long) begin
                    long_done[k]   = 1'b1;
                    r.long_mask[k] = 1'b1;
                end
            end
            r.pressed_mask[k] = deb_q[k];
        end
        keys_started = 1'b1;
        return r;
    endfunction

    // beat monitor: predict on input beats, check on output beats
    always @(posedge i_clk) begin
        t_tick_note   note;
        t_tick_result want;
        bit           beat;
        beat = 1'b0;
        if (!i_rst_n) begin
            reset_keys();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mkdb_pkg::CFG_DEBOUNCE:
                        mdl_debounce = i_cfg_data[mkdb_pkg::DEB_W-1:0];
                    mkdb_pkg::CFG_LONG_PRESS:
                        mdl_long = i_cfg_data[mkdb_pkg::LONG_W-1:0];
                    mkdb_pkg::CFG_ACTIVE_LOW:
                        mdl_active_low = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                beat = 1'b1;
                note = tick_notes.pop_front();
                want = debounce_tick(i_pin_levels);
                if (note.typed) want = note.res;
                pending_results.push_back(want);
            end
            if (o_valid && !i_stall) begin
                beat = 1'b1;
                results_seen++;
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing expected: short=%h long=%h pressed=%h",
                           o_short_mask, o_long_mask, o_pressed_mask);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_short_mask !== want.short_mask) begin
                        $error("short_mask expected %h actual %h", want.short_mask, o_short_mask);
                        mismatches++;
                    end
                    if (o_long_mask !== want.long_mask) begin
                        $error("long_mask expected %h actual %h", want.long_mask, o_long_mask);
                        mismatches++;
                    end
                    if (o_pressed_mask !== want.pressed_mask) begin
                        $error("pressed_mask expected %h actual %h",
                               want.pressed_mask, o_pressed_mask);
                        mismatches++;
                    end
                    short_events += $countones(want.short_mask);
                    long_events  += $countones(want.long_mask);
                end
            end
        end
        quiet_cycles <= beat ? 0 : quiet_cycles + 1;
    end

    // no beat on either side for too long
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("multi_key_debounce_long_press verification failed");
        $finish;
    end

    // receiver back-pressure in random bursts
    initial begin
        int stall_left;
        stall_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(1, 15) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // drive one tick beat and wait until it is taken
    task automatic send_tick(input logic [7:0] pins, input bit typed, input t_tick_result res);
        t_tick_note note;
        note.typed = typed;
        note.res   = res;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        tick_notes.push_back(note);
        i_valid      <= 1'b1;
        i_pin_levels <= pins;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // stop sending and let every outstanding result come out
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0 || tick_notes.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // write all registers plus the unused index; block must be idle
    task automatic set_config(input int deb, input int lng, input bit al);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= mkdb_pkg::CFG_DEBOUNCE;
        i_cfg_data  <= mkdb_pkg::CFG_DATA_W'(deb);
        @(posedge i_clk);
        i_cfg_index <= mkdb_pkg::CFG_LONG_PRESS;
        i_cfg_data  <= mkdb_pkg::CFG_DATA_W'(lng);
        @(posedge i_clk);
        i_cfg_index <= CFG_SPARE_IDX;
        i_cfg_data  <= mkdb_pkg::CFG_DATA_W'($urandom_range(0, 65535));
        @(posedge i_clk);
        i_cfg_index <= mkdb_pkg::CFG_ACTIVE_LOW;
        i_cfg_data  <= mkdb_pkg::CFG_DATA_W'(al);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_deb = deb;
        cur_lng = lng;
        cur_al  = al;
    endtask

    function automatic t_hold_kind pick_hold();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return HOLD_BRIEF;
        if (r < 7 || cur_lng > 200) return HOLD_SETTLE;
        return HOLD_LONG;
    endfunction

    // some keys change level, maybe with noise and bounce, then hold
    task automatic play_segment(input t_hold_kind kind);
        logic [7:0] flip;
        logic [7:0] target;
        int         n;
        int         hold;
        int         i;
        case ($urandom_range(0, 3))
            0:       flip = 8'hFF;
            1:       flip = 8'h01 << $urandom_range(0, 7);
            default: flip = 8'($urandom_range(1, 255));
        endcase
        target = cur_pins ^ flip;
        // unrelated glitches on any key
        if ($urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) send_tick(8'($urandom_range(0, 255)), 1'b0, '0);
        end
        // contact bounce on the changing keys
        if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++)
                send_tick(target ^ (flip & 8'($urandom_range(0, 255))), 1'b0, '0);
        end
        case (kind)
            HOLD_BRIEF:  hold = $urandom_range(1, cur_deb + 1);
            HOLD_SETTLE: hold = cur_deb + 1 + $urandom_range(0, 3);
            default:     hold = cur_deb + cur_lng + 1 + $urandom_range(0, 3);
        endcase
        for (i = 0; i < hold; i++) send_tick(target, 1'b0, '0);
        cur_pins = target;
    endtask

    initial begin
        t_tick_result typed_res;
        int           i;
        int           p;
        int           deb;
        int           lng;
        bit           al;
        int           budget;
        int           start;

        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= mkdb_pkg::CFG_DEBOUNCE;
        i_cfg_data   <= '0;
        i_valid      <= 1'b0;
        i_pin_levels <= 8'hFF;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        gap_pct   = 10;
        stall_pct = 10;
        for (i = 0; i < DIR_N; i++) begin
            if (int'(DIR_ROWS[i].deb) != cur_deb || int'(DIR_ROWS[i].lng) != cur_lng ||
                DIR_ROWS[i].al != cur_al) begin
                wait_idle();
                set_config(int'(DIR_ROWS[i].deb), int'(DIR_ROWS[i].lng), DIR_ROWS[i].al);
            end
            typed_res.short_mask   = DIR_ROWS[i].exp_short;
            typed_res.long_mask    = DIR_ROWS[i].exp_long;
            typed_res.pressed_mask = DIR_ROWS[i].exp_pressed;
            send_tick(DIR_ROWS[i].pins, DIR_ROWS[i].typed, typed_res);
        end
        cur_pins = DIR_ROWS[DIR_N-1].pins;

        // random phases, each with its own register settings
        for (p = 0; p < NUM_PHASES; p++) begin
            budget = 40;
            al     = $urandom_range(0, 1);
            case (p)
                0: begin deb = 3;    lng = 12;    al = 1'b1; end
                1: begin deb = 0;    lng = 1;     al = 1'b0; end
                // long press time of 60000: holds never get as far as a long event
                2: begin deb = 0;    lng = 60000; al = 1'b1; end
                3: begin deb = 0;    lng = 0;     al = 1'b0; end
                default: begin
                    deb = $urandom_range(0, 6);
                    lng = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 30);
                end
            endcase
            wait_idle();
            case (p % 3)
                0:       begin gap_pct = 6;  stall_pct = 6;  end
                1:       begin gap_pct = 15; stall_pct = 15; end
                default: begin gap_pct = 0;  stall_pct = 0;  end
            endcase
            // closing stretch runs without idling
            if (p == NUM_PHASES - 1) begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            set_config(deb, lng, al);
            start = items_sent;
            while (items_sent - start < budget) play_segment(pick_hold());
        end

        wait_idle();
        repeat (5) @(posedge i_clk);
        $display("Ran %0d tick beats through directed rows and %0d register phases.",
                 items_sent, NUM_PHASES);
        $display("Checked %0d results carrying %0d short and %0d long key events.",
                 results_seen, short_events, long_events);
        if (mismatches == 0) begin
            $display("multi_key_debounce_long_press verification clean");
        end else begin
            $display("multi_key_debounce_long_press verification failed");
        end
        $finish;
    end

endmodule
